@@ hdl/wtsg_pkg.sv @@
// Shared types, waveform codes and elaboration-time helpers for the
// waveform table sample generator. No dependencies.
package wtsg_pkg;

    localparam int PADDR_W = 3;

    localparam logic [2:0] WAVE_SINE     = 3'd1;
    localparam logic [2:0] WAVE_SQUARE   = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_SAWTOOTH = 3'd4;

    localparam logic [PADDR_W-1:0] ADDR_WAVE_SELECT = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_AMPLITUDE   = 3'd4;

    localparam logic [2:0] WAVE_SELECT_RESET = WAVE_SINE;
    localparam logic [6:0] AMPLITUDE_RESET   = 7'd100;
    localparam logic [15:0] FULL_SCALE       = 16'hFFFF;

    // pi in unsigned Q2.60, truncated
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // Taylor series divisors n*(n+1) for n = 2, 4, ..., 28
    typedef logic [63:0] taylor_div_t [0:13];
    localparam taylor_div_t TAYLOR_DIV = '{
        64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
    };

    typedef logic [15:0] amp_table_t [0:127];

    // (a * b) >> 60 in Q2.60, truncated
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // Peak code for each raw percent, saturated at 100 percent
    function automatic amp_table_t build_amp_table();
        amp_table_t tbl;
        int p;
        for (int k = 0; k < 128; k++)
        begin
            p = (k > 100) ? 100 : k;
            tbl[k] = 16'((p * 65535) / 100);
        end
        return tbl;
    endfunction

    localparam amp_table_t AMP_TABLE = build_amp_table();

endpackage

@@ hdl/wtsg_sine_rom.sv @@
// Quarter-wave sine ROM, N+1 words of SINE_FRAC_BITS fraction bits,
// filled at elaboration from a Q2.60 Taylor series. Uses wtsg_pkg.
module wtsg_sine_rom
    import wtsg_pkg::*;
#(
    parameter int TABLE_STEPS    = 1024,
    parameter int SINE_FRAC_BITS = 16
)
(
    input  logic                                 clk,
    input  logic [$clog2(TABLE_STEPS+1)-1:0]     addr,
    output logic [SINE_FRAC_BITS:0]              rd_data
);

    localparam logic [63:0] DEN     = 64'(2 * TABLE_STEPS);
    localparam logic [63:0] PI_QUOT = PI_Q60 / DEN;
    localparam logic [63:0] PI_REM  = PI_Q60 % DEN;

    typedef logic [SINE_FRAC_BITS:0] rom_t [0:TABLE_STEPS];

    function automatic rom_t build_rom();
        rom_t tbl;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        for (int v = 0; v <= TABLE_STEPS; v++)
        begin
            y = PI_QUOT * 64'(v) + (PI_REM * 64'(v)) / DEN;
            term = y;
            sum = y;
            for (int k = 0; k < 14; k++)
            begin
                term = qmul(qmul(term, y), y) / TAYLOR_DIV[k];
                if (k % 2 == 0)
                begin
                    sum = (term > sum) ? 64'd0 : sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            // round half up to the table precision
            tbl[v] = (SINE_FRAC_BITS+1)'((sum + (64'd1 << (59 - SINE_FRAC_BITS)))
                                        >> (60 - SINE_FRAC_BITS));
        end
        return tbl;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [SINE_FRAC_BITS:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= SINE_ROM[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/waveform_table_sample_generator.sv @@
// Top level of the waveform table sample generator: APB register file and
// six-stage sample pipeline. Uses wtsg_pkg and wtsg_sine_rom.
//
// Usage:
//   Pulse start with sample_index; busy is always low, so an index is taken
//   on every cycle that start is high. Each accepted index yields exactly
//   one result on sample_value / sample_valid, marked by a one-cycle done
//   strobe that comes with it. Results leave in order and one
//   can follow another in every cycle.
//   The pipeline runs index wrap (reciprocal multiply and
//   correction), sine ROM read, then a reciprocal divide by TABLE_STEPS
//   for triangle and sawtooth spread over three stages.
//   Registers (APB, byte address 0 and 4): wave_select and
//   amplitude_percent. Write them only while no sample is in flight.
//   Reset clears the pipeline valid bits and loads sine at full amplitude.
//   The receiver cannot stall; results are not held.
module waveform_table_sample_generator
    import wtsg_pkg::*;
#(
    parameter int TABLE_STEPS    = 1024,
    parameter int SINE_FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic [9:0]          sample_index,
    output logic                done,
    output logic [15:0]         sample_value,
    output logic                sample_valid
);

    localparam int NW   = $clog2(TABLE_STEPS + 1);
    localparam int IW   = $clog2(TABLE_STEPS);
    localparam int WW   = NW + 1;
    localparam int DW   = 16 + WW;
    localparam int MW   = DW - 1;
    localparam int DH   = (DW + 1) / 2;
    localparam int SUMW = DW + MW;
    localparam int SX   = 10 + NW;
    localparam int F    = SINE_FRAC_BITS;

    localparam logic [NW-1:0]  N_C       = NW'(TABLE_STEPS);
    localparam logic [IW-1:0]  HALF_C    = IW'(TABLE_STEPS / 2);
    localparam logic [SX:0]    IDX_RECIP = (SX+1)'((64'd1 << SX) / TABLE_STEPS);
    localparam logic [MW-1:0]  DIV_RECIP = MW'((64'd1 << DW) / TABLE_STEPS);
    localparam logic [F+1:0]   ONE_C     = (F+2)'(1) << F;

    // ---------------- configuration ----------------
    logic [2:0]  wave_select_reg;
    logic [6:0]  amplitude_percent_reg;
    logic [15:0] amp_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_select_reg       <= WAVE_SELECT_RESET;
            amplitude_percent_reg <= AMPLITUDE_RESET;
            amp_reg               <= FULL_SCALE;
        end
        else if (cfg_write)
        begin
            case (paddr)
                ADDR_WAVE_SELECT:
                begin
                    wave_select_reg <= pwdata[2:0];
                end
                ADDR_AMPLITUDE:
                begin
                    amplitude_percent_reg <= pwdata[6:0];
                    amp_reg               <= AMP_TABLE[pwdata[6:0]];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_WAVE_SELECT: prdata = {29'd0, wave_select_reg};
            ADDR_AMPLITUDE:   prdata = {25'd0, amplitude_percent_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign busy = 1'b0;

    // ---------------- pipeline valid bits ----------------
    logic [5:0] valid_reg;
    logic       accept;

    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[4:0], accept};
        end
    end

    // ---------------- stage 1: quotient estimate of index / N ----------------
    logic [10+SX:0] idx_prod;
    logic [9:0]     x1_reg;
    logic [7:0]     qx1_reg;

    assign idx_prod = {{(SX+1){1'b0}}, sample_index} * {10'd0, IDX_RECIP};

    // ---------------- stage 2: wrap index into 0..N-1 ----------------
    logic [NW+8:0] qxn;
    logic [NW+8:0] rx_raw;
    logic [NW+8:0] rx_fix;
    logic [IW-1:0] i2_reg;

    assign qxn    = (NW+9)'(qx1_reg) * (NW+9)'(N_C);
    assign rx_raw = (NW+9)'(x1_reg) - qxn;
    assign rx_fix = (rx_raw >= (NW+9)'(N_C)) ? rx_raw - (NW+9)'(N_C) : rx_raw;

    // ---------------- stage 3: quadrant, ROM address, dividend ----------------
    logic [IW+1:0] u3;
    logic [1:0]    quad3;
    logic [IW+1:0] rem3;
    logic [NW-1:0] rom_addr;
    logic          lower3;
    logic [WW-1:0] w3;
    logic [DW-1:0] d3_next;
    logic [F:0]    rom_data;

    always_comb
    begin
        u3 = {i2_reg, 2'b00};
        if (u3 >= (IW+2)'(3 * TABLE_STEPS))
        begin
            quad3 = 2'd3;
            rem3  = u3 - (IW+2)'(3 * TABLE_STEPS);
        end
        else if (u3 >= (IW+2)'(2 * TABLE_STEPS))
        begin
            quad3 = 2'd2;
            rem3  = u3 - (IW+2)'(2 * TABLE_STEPS);
        end
        else if (u3 >= (IW+2)'(TABLE_STEPS))
        begin
            quad3 = 2'd1;
            rem3  = u3 - (IW+2)'(TABLE_STEPS);
        end
        else
        begin
            quad3 = 2'd0;
            rem3  = u3;
        end
        // mirror odd quadrants
        rom_addr = quad3[0] ? N_C - NW'(rem3) : NW'(rem3);

        lower3 = (i2_reg < HALF_C);
        if (wave_select_reg == WAVE_SAWTOOTH)
        begin
            w3 = WW'(i2_reg);
        end
        else if (lower3)
        begin
            w3 = WW'({i2_reg, 1'b0});
        end
        else
        begin
            w3 = WW'({N_C - NW'(i2_reg), 1'b0});
        end
        d3_next = DW'(amp_reg) * DW'(w3);
    end

    wtsg_sine_rom #(
        .TABLE_STEPS    (TABLE_STEPS),
        .SINE_FRAC_BITS (SINE_FRAC_BITS)
    ) u_rom (
        .clk     (clk),
        .addr    (rom_addr),
        .rd_data (rom_data)
    );

    logic          lower3_reg;
    logic          pos3_reg;
    logic [DW-1:0] d3_reg;

    // ---------------- stage 4: sine bias, partial products ----------------
    logic [F+1:0]      biased_next;
    logic [2*DH-1:0]   pp_ll_reg;
    logic [2*DH-1:0]   pp_lh_reg;
    logic [2*DH-1:0]   pp_hl_reg;
    logic [2*DH-1:0]   pp_hh_reg;
    logic [DH-1:0]     d_lo;
    logic [DH-1:0]     d_hi;
    logic [DH-1:0]     m_lo;
    logic [DH-1:0]     m_hi;
    logic [F+1:0]      biased4_reg;
    logic              lower4_reg;
    logic [DW-1:0]     d4_reg;

    assign d_lo = d3_reg[DH-1:0];
    assign d_hi = DH'(d3_reg[DW-1:DH]);
    assign m_lo = DIV_RECIP[DH-1:0];
    assign m_hi = DH'(DIV_RECIP[MW-1:DH]);

    always_comb
    begin
        if (pos3_reg)
        begin
            biased_next = ONE_C + (F+2)'(rom_data);
        end
        else if ((F+2)'(rom_data) > ONE_C)
        begin
            biased_next = '0;
        end
        else
        begin
            biased_next = ONE_C - (F+2)'(rom_data);
        end
    end

    // ---------------- stage 5: sine scale, quotient estimate ----------------
    logic [F+17:0]   sine_prod;
    logic [SUMW-1:0] pp_sum;
    logic [15:0]     sine5_reg;
    logic [16:0]     qe5_reg;
    logic            lower5_reg;
    logic [DW-1:0]   d5_reg;

    assign sine_prod = (F+18)'(biased4_reg) * (F+18)'(amp_reg);
    assign pp_sum = SUMW'(pp_ll_reg)
                  + (SUMW'(pp_lh_reg) << DH)
                  + (SUMW'(pp_hl_reg) << DH)
                  + (SUMW'(pp_hh_reg) << (2 * DH));

    // ---------------- stage 6: quotient correction, select ----------------
    logic [16+NW:0] qn6;
    logic [DW-1:0]  r6;
    logic [16:0]    q6;
    logic [15:0]    ramp6;
    logic [15:0]    value_next;
    logic           valid_next;
    logic [15:0]    value_reg;
    logic           sval_reg;

    always_comb
    begin
        qn6   = (17+NW)'(qe5_reg) * (17+NW)'(N_C);
        r6    = d5_reg - DW'(qn6);
        q6    = (r6 >= DW'(N_C)) ? qe5_reg + 17'd1 : qe5_reg;
        ramp6 = q6[16] ? FULL_SCALE : q6[15:0];

        valid_next = 1'b1;
        case (wave_select_reg)
            WAVE_SINE:
            begin
                value_next = sine5_reg;
            end
            WAVE_SQUARE:
            begin
                value_next = lower5_reg ? 16'd0 : amp_reg;
            end
            WAVE_TRIANGLE, WAVE_SAWTOOTH:
            begin
                value_next = ramp6;
            end
            default:
            begin
                value_next = 16'd0;
                valid_next = 1'b0;
            end
        endcase
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        x1_reg      <= sample_index;
        qx1_reg     <= idx_prod[SX +: 8];

        i2_reg      <= IW'(rx_fix);

        lower3_reg  <= lower3;
        pos3_reg    <= ~quad3[1];
        d3_reg      <= d3_next;

        biased4_reg <= biased_next;
        lower4_reg  <= lower3_reg;
        d4_reg      <= d3_reg;
        pp_ll_reg   <= (2*DH)'(d_lo) * (2*DH)'(m_lo);
        pp_lh_reg   <= (2*DH)'(d_lo) * (2*DH)'(m_hi);
        pp_hl_reg   <= (2*DH)'(d_hi) * (2*DH)'(m_lo);
        pp_hh_reg   <= (2*DH)'(d_hi) * (2*DH)'(m_hi);

        sine5_reg   <= sine_prod[F+1 +: 16];
        qe5_reg     <= pp_sum[DW +: 17];
        lower5_reg  <= lower4_reg;
        d5_reg      <= d4_reg;

        value_reg   <= value_next;
        sval_reg    <= valid_next;
    end

    assign done         = valid_reg[5];
    assign sample_value = value_reg;
    assign sample_valid = sval_reg;

endmodule

@@ tb/sv/waveform_table_sample_generator_checker.sv @@
// Scoreboard for the waveform table sample generator: mirrors the two
// registers from the APB port, predicts each DAC sample and checks results.
// Depends on wtsg_pkg for waveform codes and register addresses.
module waveform_table_sample_generator_checker
    import wtsg_pkg::*;
#(
    parameter int STEPS     = 1024,
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    input  logic                start,
    input  logic                busy,
    input  logic [9:0]          sample_index,
    input  logic                done,
    input  logic [15:0]         sample_value,
    input  logic                sample_valid,
    output int unsigned         fail_count,
    output int unsigned         pending,
    output int unsigned         checked
);

    // pi in unsigned Q2.60, truncated
    localparam logic [63:0] PI_Q2_60 = 64'h3243F6A8885A308D;
    localparam int          PRINT_CAP = 40;

    typedef struct packed {
        logic [9:0]  index;
        logic [15:0] value;
        logic        valid;
    } dac_sample_t;

    logic [2:0]         wave_cfg    = WAVE_SINE;
    logic [6:0]         percent_cfg = 7'd100;
    dac_sample_t        expected_samples [$];
    logic [FRAC_BITS:0] quarter_rom [0:STEPS];

    initial
    begin
        fail_count = 0;
        checked    = 0;
        pending    = 0;
    end

    task automatic report(input string what);
        if (fail_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // truncated Q2.60 product
    function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = {64'd0, a} * {64'd0, b};
        wide = wide >> 60;
        return wide[63:0];
    endfunction

    // round(sin((pi/2) * v / STEPS) * 2^FRAC_BITS) by a truncated Taylor series
    function automatic logic [FRAC_BITS:0] quarter_entry(input int unsigned v);
        logic [63:0] angle;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] den;
        logic        subtract;
        int          n;
        den      = 64'(2 * STEPS);
        angle    = (PI_Q2_60 / den) * 64'(v) + ((PI_Q2_60 % den) * 64'(v)) / den;
        term     = angle;
        acc      = angle;
        subtract = 1'b1;
        for (n = 2; n <= 28; n += 2)
        begin
            term = q60_product(q60_product(term, angle), angle) / 64'(n * (n + 1));
            if (subtract)
                acc = (term > acc) ? 64'd0 : acc - term;
            else
                acc = acc + term;
            subtract = !subtract;
        end
        acc = (acc + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
        return acc[FRAC_BITS:0];
    endfunction

    initial
    begin
        for (int v = 0; v <= STEPS; v++)
            quarter_rom[v] = quarter_entry(v);
    end

    function automatic dac_sample_t predict_sample(input logic [2:0] sel,
                                                   input logic [6:0] pct,
                                                   input logic [9:0] idx);
        dac_sample_t     s;
        longint unsigned pos;
        longint unsigned peak;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned mag;
        longint unsigned biased;
        longint unsigned unity;
        longint unsigned code;
        pos     = 64'(idx) % 64'(STEPS);
        peak    = ((pct > 7'd100) ? 64'd100 : 64'(pct)) * 64'd65535 / 64'd100;
        unity   = 64'd1 << FRAC_BITS;
        code    = 0;
        s.valid = 1'b1;
        case (sel)
            WAVE_SINE:
            begin
                quad = (4 * pos) / 64'(STEPS);
                rem  = (4 * pos) % 64'(STEPS);
                // odd quadrants run the quarter wave backwards
                if (quad == 0 || quad == 2)
                    mag = 64'(quarter_rom[rem]);
                else
                    mag = 64'(quarter_rom[64'(STEPS) - rem]);
                if (quad < 2)
                    biased = unity + mag;
                else
                    biased = (mag > unity) ? 64'd0 : unity - mag;
                code = (biased * peak) >> (FRAC_BITS + 1);
            end
            WAVE_SQUARE:
                code = (pos < 64'(STEPS / 2)) ? 64'd0 : peak;
            WAVE_TRIANGLE:
            begin
                if (pos < 64'(STEPS / 2))
                    code = (2 * peak * pos) / 64'(STEPS);
                else
                    code = (2 * peak * (64'(STEPS) - pos)) / 64'(STEPS);
            end
            WAVE_SAWTOOTH:
                code = (peak * pos) / 64'(STEPS);
            default:
            begin
                s.valid = 1'b0;
                code    = 0;
            end
        endcase
        if (code > 64'd65535)
            code = 64'd65535;
        s.value = code[15:0];
        s.index = idx;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        dac_sample_t want;
        logic [31:0] reg_value;
        if (!rst_n)
        begin
            wave_cfg    <= WAVE_SINE;
            percent_cfg <= 7'd100;
            expected_samples.delete();
            pending     <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_samples.size() == 0)
                    report($sformatf("unexpected sample value %0h valid %b",
                                     sample_value, sample_valid));
                else
                begin
                    want = expected_samples.pop_front();
                    checked++;
                    if (sample_value !== want.value)
                        report($sformatf("index %0d: sample_value %0h, expected %0h",
                                         want.index, sample_value, want.value));
                    if (sample_valid !== want.valid)
                        report($sformatf("index %0d: sample_valid %b, expected %b",
                                         want.index, sample_valid, want.valid));
                end
            end
            // predict with the settings in force before this edge
            if (start && !busy)
                expected_samples.push_back(predict_sample(wave_cfg, percent_cfg, sample_index));
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr)
                        ADDR_WAVE_SELECT: wave_cfg    <= pwdata[2:0];
                        ADDR_AMPLITUDE:   percent_cfg <= pwdata[6:0];
                        default:          ;
                    endcase
                end
                else if (paddr == ADDR_WAVE_SELECT || paddr == ADDR_AMPLITUDE)
                begin
                    reg_value = (paddr == ADDR_WAVE_SELECT) ? 32'(wave_cfg) : 32'(percent_cfg);
                    if (prdata !== reg_value)
                        report($sformatf("register read at %0h: %0h, expected %0h",
                                         paddr, prdata, reg_value));
                end
            end
            pending <= expected_samples.size();
        end
    end

endmodule

@@ tb/sv/waveform_table_sample_generator_tb.sv @@
// Top of the waveform table sample generator testbench: clock, reset, APB
// register traffic and sample index stimulus; verdict from the checker.
// Depends on wtsg_pkg, the block and waveform_table_sample_generator_checker.
module waveform_table_sample_generator_tb
    import wtsg_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_ITEMS   = 1350;

    // selector codes outside the four waveforms
    localparam logic [2:0] WAVE_NONE     = 3'd0;
    localparam logic [2:0] WAVE_TOP_CODE = 3'd7;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               start        = 1'b0;
    logic               busy;
    logic [9:0]         sample_index = '0;
    logic               done;
    logic [15:0]        sample_value;
    logic               sample_valid;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned settings_used = 0;
    int unsigned idle_cycles   = 0;

    logic [9:0] corner_index [9] = '{10'd0, 10'd255, 10'd256, 10'd511, 10'd512,
                                      10'd513, 10'd767, 10'd768, 10'd1023};

    always #2 clk = ~clk;

    waveform_table_sample_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .sample_index (sample_index),
        .done         (done),
        .sample_value (sample_value),
        .sample_valid (sample_valid)
    );

    waveform_table_sample_generator_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .sample_index (sample_index),
        .done         (done),
        .sample_value (sample_value),
        .sample_valid (sample_valid),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    // drop the run if nothing is transferred for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d samples outstanding",
                     idle_cycles, pending);
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // setup phase, access phase held until pready, then release the bus
    task automatic apb_access(input logic write_en, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [2:0] sel, input logic [6:0] pct);
        apb_access(1'b1, ADDR_WAVE_SELECT, {29'd0, sel});
        apb_access(1'b1, ADDR_AMPLITUDE, {25'd0, pct});
        apb_access(1'b0, ADDR_WAVE_SELECT, 32'd0);
        apb_access(1'b0, ADDR_AMPLITUDE, 32'd0);
        settings_used++;
    endtask

    // returns at the edge that took the transfer; start is left high
    task automatic send_index(input logic [9:0] idx, input int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        sample_index <= idx;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off until every sample in flight has come back
    task automatic finish_phase();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [6:0] pick_percent();
        case ($urandom_range(0, 9))
            0:       return 7'd0;
            1:       return 7'd100;
            2:       return 7'd127;
            3:       return 7'($urandom_range(101, 127));
            default: return 7'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic logic [9:0] pick_index();
        if ($urandom_range(0, 7) == 0)
            return corner_index[$urandom_range(0, 8)];
        return 10'($urandom_range(0, 1023));
    endfunction

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned count;
        int unsigned gap_mode;
        int unsigned gap;
        logic [2:0]  sel;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values read back, then sine at full scale across the quadrants
        apb_access(1'b0, ADDR_WAVE_SELECT, 32'd0);
        apb_access(1'b0, ADDR_AMPLITUDE, 32'd0);
        send_index(10'd0, 0);
        send_index(10'd256, 0);
        send_index(10'd512, 0);
        send_index(10'd768, 0);
        send_index(10'd1023, 0);
        send_index(10'd1, 3);
        finish_phase();

        apply_setting(WAVE_SQUARE, 7'd0);
        send_index(10'd511, 0);
        send_index(10'd512, 0);
        finish_phase();

        // percent above 100 saturates; triangle turns at the midpoint
        apply_setting(WAVE_TRIANGLE, 7'd127);
        send_index(10'd0, 0);
        send_index(10'd511, 0);
        send_index(10'd512, 0);
        send_index(10'd513, 1);
        send_index(10'd1023, 0);
        finish_phase();

        apply_setting(WAVE_SAWTOOTH, 7'd100);
        send_index(10'd0, 0);
        send_index(10'd1023, 0);
        send_index(10'd512, 0);
        finish_phase();

        apply_setting(WAVE_SINE, 7'd1);
        send_index(10'd256, 0);
        send_index(10'd768, 0);
        finish_phase();

        // unknown selectors give a zero sample marked invalid
        apply_setting(WAVE_NONE, 7'd50);
        send_index(10'h2AA, 0);
        finish_phase();
        for (int s = WAVE_SAWTOOTH + 1; s <= WAVE_TOP_CODE; s++)
        begin
            apply_setting(3'(s), 7'($urandom_range(0, 127)));
            send_index(10'h155, 0);
            finish_phase();
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
                sel = 3'($urandom_range(0, 7));
            else
                sel = 3'($urandom_range(WAVE_SINE, WAVE_SAWTOOTH));
            apply_setting(sel, pick_percent());
            count    = $urandom_range(20, 80);
            gap_mode = $urandom_range(0, 2);
            for (int k = 0; k < count; k++)
            begin
                case (gap_mode)
                    0:       gap = 0;
                    1:       gap = $urandom_range(0, 11);
                    default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
                endcase
                send_index(pick_index(), gap);
            end
            sent += count;
            finish_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d samples checked over %0d register settings", checked, settings_used);
        $display("selectors 0 to 7, percent 0 to 127 with saturation, index corners and gaps");
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
